### rtl/brush_stamp_canvas_unit_assert.svh
// ----------------------------------------------------------------------------
// brush_stamp_canvas_unit assertion macros
// Concurrent check helpers shared by the canvas RTL.
// ----------------------------------------------------------------------------
`ifndef BRUSH_STAMP_CANVAS_UNIT_ASSERT_SVH
`define BRUSH_STAMP_CANVAS_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brush_stamp_canvas_unit: implication check failed");

// condition must never be seen
`define BSC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("brush_stamp_canvas_unit: forbidden condition seen");

`endif

### rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helper functions of the brush stamp canvas.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int GRID_SIDE   = 28;
   localparam int CELL_COUNT  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int POS_W       = $clog2(GRID_SIDE);
   localparam int COORD_W     = 6;
   localparam int NB_W        = COORD_W + 1;
   localparam int FUNC_W      = 2;
   localparam int CELL_W      = 8;
   localparam int BRIGHT_W    = 3;
   localparam int PROD_W      = CELL_W + BRIGHT_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int NB_CNT_W    = 4;
   localparam int NB_LAST     = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CELL_FULL  = (1 << CELL_W) - 1;
   localparam int BRIGHT_MAX = 7;
   localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(CELL_FULL);

   localparam logic [CELL_W-1:0] WEIGHT_CENTER_RST = 8'd50;
   localparam logic [CELL_W-1:0] WEIGHT_EDGE_RST   = 8'd25;
   localparam logic [CELL_W-1:0] WEIGHT_CORNER_RST = 8'd5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PAINT      = 2'd0,
      FUNC_CLEAR_CELL = 2'd1,
      FUNC_CLEAR_ALL  = 2'd2,
      FUNC_READ       = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WEIGHT_CENTER = 2'd0,
      CSR_WEIGHT_EDGE   = 2'd1,
      CSR_WEIGHT_CORNER = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CELL_W-1:0] center_w;
      logic [CELL_W-1:0] edge_w;
      logic [CELL_W-1:0] corner_w;
   } weights_type;

   typedef struct packed {
      func_type                   func;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic                       on_grid;
      logic [ADDR_W-1:0]          addr;
   } cmd_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } nb_offset_type;

   function automatic logic in_grid(logic signed [NB_W-1:0] x, logic signed [NB_W-1:0] y);
      logic signed [NB_W-1:0] side;
      side = $signed(NB_W'(GRID_SIDE));
      return (x >= 0) && (x < side) && (y >= 0) && (y < side);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(logic signed [NB_W-1:0] x,
                                                   logic signed [NB_W-1:0] y);
      return ADDR_W'(ADDR_W'(y[POS_W-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(x[POS_W-1:0]));
   endfunction

   function automatic logic [CELL_W-1:0] sat_add(logic [CELL_W-1:0] a, logic [CELL_W-1:0] w);
      logic [CELL_W:0] sum;
      sum = {1'b0, a} + {1'b0, w};
      return sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
   endfunction

   function automatic logic [BRIGHT_W-1:0] brightness(logic [CELL_W-1:0] v);
      logic [PROD_W-1:0]   p;
      logic [BRIGHT_W-1:0] b;
      p = PROD_W'(v) * PROD_W'(BRIGHT_MAX);
      b = '0;
      for (int k = 1; k <= BRIGHT_MAX; k++) begin
         if (p >= PROD_W'(CELL_FULL * k)) begin
            b = b + BRIGHT_W'(1);
         end
      end
      return b;
   endfunction

   function automatic nb_offset_type nb_offset(logic [NB_CNT_W-1:0] idx);
      nb_offset_type o;
      case (idx)
         4'd0: begin o.dx = -2'sd1; o.dy = -2'sd1; end
         4'd1: begin o.dx =  2'sd0; o.dy = -2'sd1; end
         4'd2: begin o.dx =  2'sd1; o.dy = -2'sd1; end
         4'd3: begin o.dx = -2'sd1; o.dy =  2'sd0; end
         4'd4: begin o.dx =  2'sd0; o.dy =  2'sd0; end
         4'd5: begin o.dx =  2'sd1; o.dy =  2'sd0; end
         4'd6: begin o.dx = -2'sd1; o.dy =  2'sd1; end
         4'd7: begin o.dx =  2'sd0; o.dy =  2'sd1; end
         default: begin o.dx = 2'sd1; o.dy = 2'sd1; end
      endcase
      return o;
   endfunction

endpackage

### rtl/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc_if
// Valid/ready channels of the brush stamp canvas: request and response.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                                valid;
   logic                                ready;
   logic [bsc_pkg::FUNC_W-1:0]          func;
   logic signed [bsc_pkg::COORD_W-1:0]  col;
   logic signed [bsc_pkg::COORD_W-1:0]  row;

   modport source (output valid, func, col, row, input ready);
   modport sink   (input valid, func, col, row, output ready);
endinterface

interface bsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsc_pkg::CELL_W-1:0]    cell_value;
   logic [bsc_pkg::BRIGHT_W-1:0]  brightness;

   modport source (output valid, cell_value, brightness, input ready);
   modport sink   (input valid, cell_value, brightness, output ready);
endinterface

### rtl/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// Request intake: decodes each item and resolves its grid cell address.
// ----------------------------------------------------------------------------
module bsc_front (
   bsc_req_if.sink           req,
   input  logic              init_busy,
   input  logic              q_full,
   output logic              q_push,
   output bsc_pkg::cmd_type  q_data
);
   import bsc_pkg::*;

   logic signed [NB_W-1:0] x;
   logic signed [NB_W-1:0] y;
   logic                   on_grid;

   assign x       = NB_W'(req.col);
   assign y       = NB_W'(req.row);
   assign on_grid = in_grid(x, y);

   assign req.ready = !q_full && !init_busy;
   assign q_push    = req.valid && req.ready;

   always_comb begin
      q_data.func    = func_type'(req.func);
      q_data.col     = req.col;
      q_data.row     = req.row;
      q_data.on_grid = on_grid;
      q_data.addr    = on_grid ? cell_addr(x, y) : '0;
   end

endmodule

### rtl/bsc_queue.sv
// ----------------------------------------------------------------------------
// bsc_queue
// Short command queue between request intake and the cell engine.
// ----------------------------------------------------------------------------
module bsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsc_pkg::cmd_type  push_data,
   input  logic              pop,
   output bsc_pkg::cmd_type  pop_data,
   output logic              full,
   output logic              empty
);
   import bsc_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back
// Cell engine: owns the grid memory, runs brush read-modify-writes, clears
// and reads, and holds the response register.
// ----------------------------------------------------------------------------
module bsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bsc_pkg::weights_type  weights,
   input  logic                  q_empty,
   input  bsc_pkg::cmd_type      q_data,
   output logic                  q_pop,
   output logic                  init_busy,
   bsc_rsp_if.source             rsp
);
   import bsc_pkg::*;

   typedef enum logic [7:0] {
      S_INIT  = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_EXEC  = 8'b0000_0100,
      S_NB    = 8'b0000_1000,
      S_NBW   = 8'b0001_0000,
      S_CLR   = 8'b0010_0000,
      S_RDW   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   logic [CELL_W-1:0]     mem [CELL_COUNT];

   state_type             state_ff;
   state_type             state_in;
   cmd_type               cmd_ff;
   cmd_type               cmd_in;
   logic [ADDR_W-1:0]     sweep_ff;
   logic [ADDR_W-1:0]     sweep_in;
   logic [NB_CNT_W-1:0]   nb_ff;
   logic [NB_CNT_W-1:0]   nb_in;
   logic [ADDR_W-1:0]     wr_addr_ff;
   logic [ADDR_W-1:0]     wr_addr_in;
   logic [CELL_W-1:0]     wr_weight_ff;
   logic [CELL_W-1:0]     wr_weight_in;
   logic [CELL_W-1:0]     value_ff;
   logic [CELL_W-1:0]     value_in;
   logic [CELL_W-1:0]     rd_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CELL_W-1:0]     rsp_value_ff;
   logic [CELL_W-1:0]     rsp_value_in;
   logic [BRIGHT_W-1:0]   rsp_bright_ff;
   logic [BRIGHT_W-1:0]   rsp_bright_in;

   nb_offset_type          nb;
   logic signed [NB_W-1:0] nx;
   logic signed [NB_W-1:0] ny;
   logic                   nb_on;
   logic [ADDR_W-1:0]      nb_addr;
   logic [CELL_W-1:0]      nb_weight;
   logic                   nb_last;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_wa;
   logic [CELL_W-1:0]      mem_wd;
   logic                   out_free;
   logic                   rsp_load;
   logic                   sweep_last;

   assign nb         = nb_offset(nb_ff);
   assign nx         = NB_W'(cmd_ff.col) + NB_W'(nb.dx);
   assign ny         = NB_W'(cmd_ff.row) + NB_W'(nb.dy);
   assign nb_on      = in_grid(nx, ny);
   assign nb_addr    = cell_addr(nx, ny);
   assign nb_last    = (nb_ff == NB_CNT_W'(NB_LAST));
   assign sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign rd_addr    = (state_ff == S_NB) ? nb_addr : cmd_ff.addr;
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign init_busy  = (state_ff == S_INIT);

   always_comb begin
      if (nb.dx == 0 && nb.dy == 0) begin
         nb_weight = weights.center_w;
      end else if (nb.dx == 0 || nb.dy == 0) begin
         nb_weight = weights.edge_w;
      end else begin
         nb_weight = weights.corner_w;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sweep_in     = sweep_ff;
      nb_in        = nb_ff;
      wr_addr_in   = wr_addr_ff;
      wr_weight_in = wr_weight_ff;
      value_in     = value_ff;
      mem_we       = 1'b0;
      mem_wa       = sweep_ff;
      mem_wd       = '0;
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         S_INIT, S_CLR: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_last) begin
               sweep_in = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_RESP;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            value_in = '0;
            case (cmd_ff.func)
               FUNC_PAINT: begin
                  nb_in    = '0;
                  state_in = S_NB;
               end
               FUNC_CLEAR_CELL: begin
                  mem_we   = cmd_ff.on_grid;
                  mem_wa   = cmd_ff.addr;
                  state_in = S_RESP;
               end
               FUNC_CLEAR_ALL: begin
                  state_in = S_CLR;
               end
               default: begin
                  state_in = S_RDW;
               end
            endcase
         end
         S_RDW: begin
            value_in = cmd_ff.on_grid ? rd_data_ff : '0;
            state_in = S_RESP;
         end
         S_NB: begin
            if (nb_on) begin
               wr_addr_in   = nb_addr;
               wr_weight_in = nb_weight;
               state_in     = S_NBW;
            end else if (nb_last) begin
               state_in = S_RESP;
            end else begin
               nb_in = nb_ff + NB_CNT_W'(1);
            end
         end
         S_NBW: begin
            mem_we = 1'b1;
            mem_wa = wr_addr_ff;
            mem_wd = sat_add(rd_data_ff, wr_weight_ff);
            nb_in  = nb_ff + NB_CNT_W'(1);
            state_in = nb_last ? S_RESP : S_NB;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_bright_in = rsp_bright_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = value_ff;
         rsp_bright_in = brightness(value_ff);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      wr_addr_ff    <= wr_addr_in;
      wr_weight_ff  <= wr_weight_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_bright_ff <= rsp_bright_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cell_value = rsp_value_ff;
   assign rsp.brightness = rsp_bright_ff;

endmodule

### rtl/brush_stamp_canvas_unit.sv
// ----------------------------------------------------------------------------
// brush_stamp_canvas_unit
// A 28 by 28 canvas of 8-bit cells kept in one single-port-write memory with
// a registered read. Every request item returns exactly one response item.
// Paint visits each of the nine brush cells in turn and, for each brush
// cell that lands on the grid, does a read, then a saturating write. Clear
// all walks the memory one cell a cycle. After reset the unit first zeroes
// the memory in a pass with req.ready low; weight writes on the csr port
// are taken during that pass.
// A four-entry command queue lets requests be taken while the engine is
// busy, and the response register lets the engine go on while a result waits.
// ----------------------------------------------------------------------------
`include "brush_stamp_canvas_unit_assert.svh"

module brush_stamp_canvas_unit (
   input  logic                                clock,
   input  logic                                reset,
   bsc_req_if.sink                             req,
   bsc_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bsc_pkg::*;

   weights_type  weights_ff;
   weights_type  weights_in;
   logic         init_busy;
   logic         q_full;
   logic         q_empty;
   logic         q_push;
   logic         q_pop;
   cmd_type      q_push_data;
   cmd_type      q_pop_data;

   always_comb begin
      weights_in = weights_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WEIGHT_CENTER: weights_in.center_w = csr_wdata[CELL_W-1:0];
            CSR_WEIGHT_EDGE:   weights_in.edge_w   = csr_wdata[CELL_W-1:0];
            CSR_WEIGHT_CORNER: weights_in.corner_w = csr_wdata[CELL_W-1:0];
            default:           weights_in = weights_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff.center_w <= WEIGHT_CENTER_RST;
         weights_ff.edge_w   <= WEIGHT_EDGE_RST;
         weights_ff.corner_w <= WEIGHT_CORNER_RST;
      end else begin
         weights_ff <= weights_in;
      end
   end

   bsc_front u_front (
      .req       (req),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   bsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   bsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .weights   (weights_ff),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp       (rsp)
   );

   `BSC_ASSERT_IMPLY(a_init_blocks_req, clock, reset, init_busy, !req.ready)
   `BSC_ASSERT_IMPLY(a_init_no_rsp, clock, reset, init_busy, !rsp.valid)
   `BSC_ASSERT_IMPLY(a_full_cell_bright, clock, reset, rsp.valid && (rsp.cell_value == CELL_MAX), rsp.brightness == BRIGHT_W'(BRIGHT_MAX))
   `BSC_ASSERT_NEVER(a_dark_cell_bright, clock, reset, rsp.valid && (rsp.cell_value == '0) && (rsp.brightness != '0))

endmodule
